### hw/rtl/otsa_pkg.sv
package otsa_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CAP_W    = 9;
  localparam int unsigned SLOT_W   = 9;
  localparam int unsigned OWN_IN_W = 16;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned OP_W     = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 3'd0,
    OP_ALLOC_AT   = 3'd1,
    OP_FREE_SLOT  = 3'd2,
    OP_FREE_OWNER = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_TABLE  = 3'd1,
    ST_BAD_ARG   = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_TAKEN     = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_e;

endpackage

### hw/rtl/otsa_ram.sv
module otsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/owner_tagged_slot_allocator.sv
// Owner-tagged first-fit slot allocator. A table of slots, each empty or held
// by a nonzero owner id, lives in one synchronous RAM. Start an operation by
// raising start_i while busy_o is low; the result appears for exactly one
// cycle with result_valid_o and cannot be held off, so capture it then.
// Operations rejected on their arguments (no table, unknown op, zero owner,
// slot out of range) return their result in the cycle after the transfer;
// allocate-at, free-slot and query read the named slot, then answer, and on
// success allocate-at and free-slot write it back; allocate and free-by-owner
// scan the RAM one entry per cycle from slot 1, stopping at the first match or
// at the last slot. The single RAM read port sets this order. After reset and
// every capacity write a clearing pass over the whole RAM empties the table;
// busy_o stays high during it. The capacity port is always ready; write it
// only while no operation is in flight. Capacities above MAX_SLOTS are clipped.
module owner_tagged_slot_allocator
  import otsa_pkg::*;
#(
  parameter int unsigned MAX_SLOTS  = 256,
  parameter int unsigned OWNER_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                start_i,
  output logic                busy_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [OWN_IN_W-1:0] owner_i,
  // capacity register
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CAP_W-1:0]    cfg_capacity_i,
  // result channel
  output logic                result_valid_o,
  output logic [STAT_W-1:0]   status_o,
  output logic [SLOT_W-1:0]   slot_out_o,
  output logic [OWN_IN_W-1:0] owner_out_o,
  output logic [CAP_W-1:0]    used_count_o,
  output logic [CAP_W-1:0]    free_count_o
);

  localparam int unsigned AW      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CapMax  = (1 << CAP_W) - 1;
  localparam int unsigned CapLim  = (MAX_SLOTS > CapMax) ? CapMax : MAX_SLOTS;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_SCAN  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [CAP_W-1:0]      cap_q, cap_d;
  logic [CAP_W-1:0]      occ_q, occ_d;
  logic [CAP_W-1:0]      scan_q, scan_d;
  op_e                   op_q, op_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [OWNER_BITS-1:0] owner_q, owner_d;

  logic                  res_valid_q, res_valid_d;
  status_e               res_status_q, res_status_d;
  logic [SLOT_W-1:0]     res_slot_q, res_slot_d;
  logic [OWN_IN_W-1:0]   res_owner_q, res_owner_d;
  logic [CAP_W-1:0]      res_used_q, res_used_d;
  logic [CAP_W-1:0]      res_free_q, res_free_d;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [OWNER_BITS-1:0] mem_wdata, mem_rdata;

  logic [OWNER_BITS-1:0] owner_in;
  logic                  slot_ok, needs_owner, needs_slot, accept, cfg_wr;
  logic                  scan_hit, scan_last;
  logic [SLOT_W-1:0]     slot_m1;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i & ~busy_o;

  // Take the owner in its low OWNER_BITS bits
  assign owner_in    = OWNER_BITS'(owner_i);
  assign slot_m1     = slot_i - SLOT_W'(1);
  assign slot_ok     = (slot_i != '0) && (CAP_W'(slot_i) <= cap_q);
  assign needs_owner = (op_i == OP_ALLOC) || (op_i == OP_ALLOC_AT) ||
                       (op_i == OP_FREE_OWNER);
  assign needs_slot  = (op_i == OP_ALLOC_AT) || (op_i == OP_FREE_SLOT) ||
                       (op_i == OP_QUERY);

  assign scan_hit  = (op_q == OP_ALLOC) ? (mem_rdata == '0) : (mem_rdata == owner_q);
  assign scan_last = (scan_q == cap_q - CAP_W'(1));

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cap_d        = cap_q;
    occ_d        = occ_q;
    scan_d       = scan_q;
    op_d         = op_q;
    slot_d       = slot_q;
    owner_d      = owner_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_owner_d  = res_owner_q;
    mem_we       = 1'b0;
    mem_waddr    = clr_q;
    mem_wdata    = '0;
    mem_raddr    = AW'(slot_m1);

    case (state_q)
      S_CLEAR: begin
        // Sweep the table to empty, one entry a cycle
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(MAX_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d    = op_e'(op_i);
          slot_d  = slot_i;
          owner_d = owner_in;
          scan_d  = '0;
          if (cap_q == '0) begin
            res_valid_d = 1'b1; res_status_d = ST_NO_TABLE;
            res_slot_d  = '0;   res_owner_d  = '0;
          end else if (op_i > OP_QUERY) begin
            res_valid_d = 1'b1; res_status_d = ST_BAD_ARG;
            res_slot_d  = '0;   res_owner_d  = '0;
          end else if (needs_owner && (owner_in == '0)) begin
            res_valid_d = 1'b1; res_status_d = ST_BAD_ARG;
            res_slot_d  = '0;   res_owner_d  = '0;
          end else if (needs_slot && !slot_ok) begin
            res_valid_d = 1'b1; res_status_d = ST_BAD_ARG;
            res_slot_d  = '0;   res_owner_d  = '0;
          end else if (needs_slot) begin
            state_d = S_LOOK;
          end else begin
            // Scan starts at slot 1
            mem_raddr = '0;
            state_d   = S_SCAN;
          end
        end
      end
      S_LOOK: begin
        // Read data for the named slot is here; modify and write back
        mem_waddr   = AW'(slot_q - SLOT_W'(1));
        res_valid_d = 1'b1;
        res_slot_d  = slot_q;
        res_owner_d = '0;
        state_d     = S_IDLE;
        case (op_q)
          OP_ALLOC_AT: begin
            if (mem_rdata != '0) begin
              res_status_d = ST_TAKEN;
              res_slot_d   = '0;
            end else begin
              res_status_d = ST_OK;
              mem_we       = 1'b1;
              mem_wdata    = owner_q;
              occ_d        = occ_q + CAP_W'(1);
            end
          end
          OP_FREE_SLOT: begin
            if (mem_rdata == '0) begin
              res_status_d = ST_EMPTY;
              res_slot_d   = '0;
            end else begin
              res_status_d = ST_OK;
              res_owner_d  = OWN_IN_W'(mem_rdata);
              mem_we       = 1'b1;
              occ_d        = occ_q - CAP_W'(1);
            end
          end
          default: begin
            res_status_d = ST_OK;
            res_owner_d  = OWN_IN_W'(mem_rdata);
          end
        endcase
      end
      S_SCAN: begin
        // Data for entry scan_q is here; read of the next entry goes out now
        mem_raddr = AW'(scan_q + CAP_W'(1));
        mem_waddr = AW'(scan_q);
        scan_d    = scan_q + CAP_W'(1);
        if (scan_hit) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_OK;
          res_slot_d   = SLOT_W'(scan_q + CAP_W'(1));
          res_owner_d  = '0;
          mem_we       = 1'b1;
          state_d      = S_IDLE;
          if (op_q == OP_ALLOC) begin
            mem_wdata = owner_q;
            occ_d     = occ_q + CAP_W'(1);
          end else begin
            occ_d     = occ_q - CAP_W'(1);
          end
        end else if (scan_last) begin
          res_valid_d  = 1'b1;
          res_status_d = (op_q == OP_ALLOC) ? ST_FULL : ST_NOT_FOUND;
          res_slot_d   = '0;
          res_owner_d  = '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase

    // A capacity write makes a fresh table: restart the clearing pass
    if (cfg_wr) begin
      cap_d   = (cfg_capacity_i > CAP_W'(CapLim)) ? CAP_W'(CapLim) : cfg_capacity_i;
      occ_d   = '0;
      clr_d   = '0;
      state_d = S_CLEAR;
    end
  end

  // Counts reported with every result reflect the table after the operation
  assign res_used_d = occ_d;
  assign res_free_d = cap_q - occ_d;

  otsa_ram #(
    .WIDTH (OWNER_BITS),
    .DEPTH (MAX_SLOTS),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cap_q       <= '0;
      occ_q       <= '0;
      scan_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cap_q       <= cap_d;
      occ_q       <= occ_d;
      scan_q      <= scan_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Hold the command and result payload; no reset needed
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    slot_q  <= slot_d;
    owner_q <= owner_d;
    if (res_valid_d) begin
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_owner_q  <= res_owner_d;
      res_used_q   <= res_used_d;
      res_free_q   <= res_free_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign slot_out_o     = res_slot_q;
  assign owner_out_o    = res_owner_q;
  assign used_count_o   = res_used_q;
  assign free_count_o   = res_free_q;

  // The occupancy count never runs past the table size
  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= cap_q)
    else $error("occupancy above capacity");

  // Reported counts always add up to the capacity
  a_counts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_used_q + res_free_q) == cap_q)
    else $error("used and free counts do not sum to capacity");

  // A successful operation always names a slot
  a_ok_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_status_q == ST_OK)) |-> (res_slot_q != '0))
    else $error("ok result without a slot");

  // The table is written only by the clearing pass or a writeback
  a_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != S_IDLE))
    else $error("table written while idle");

endmodule
